FILE: hdl/scdr_pkg.sv
// ============================================================================
// scdr_pkg - shared types and constants for the SPH density rate core
// Register indexes, datapath command/status records, multiplier selects and
// the saturating 64-bit add used by the datapath.
// ============================================================================
package scdr_pkg;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 31;

  localparam logic [CFG_IDX_W-1:0] CFG_DIMENSION  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MASS       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DELTA_EN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DELTA_COEF = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SMOOTH     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SOUND      = 3'd5;

  localparam logic [1:0] DIM_3D = 2'd3;

  // stream widths
  localparam int IN_TDATA_W  = 320;
  localparam int OUT_TDATA_W = 32;
  localparam int OUT_TUSER_W = 2;

  localparam logic MODE_BEGIN = 1'b0;

  // shared multiplier operand selects
  localparam logic [2:0] MUL_NONE = 3'd0;
  localparam logic [2:0] MUL_LEN  = 3'd1;  // |d| * |d|
  localparam logic [2:0] MUL_CON  = 3'd2;  // |dv| * |g|
  localparam logic [2:0] MUL_DOT  = 3'd3;  // |d| * |g|
  localparam logic [2:0] MUL_RR   = 3'd4;  // distance ratio * density ratio
  localparam logic [2:0] MUL_HI   = 3'd5;  // upper half of wide operand
  localparam logic [2:0] MUL_LO   = 3'd6;  // lower half of wide operand

  // output chain steps
  localparam logic [2:0] OSTEP_CONT   = 3'd0;
  localparam logic [2:0] OSTEP_DCOEF  = 3'd1;
  localparam logic [2:0] OSTEP_SMOOTH = 3'd2;
  localparam logic [2:0] OSTEP_SOUND  = 3'd3;
  localparam logic [2:0] OSTEP_MASS   = 3'd4;

  // divider operand selects
  localparam logic DIV_RF = 1'b0;
  localparam logic DIV_RR = 1'b1;

  typedef struct packed {
    logic       load_own;
    logic       load_nb;
    logic [2:0] mul_sel;
    logic [1:0] comp;
    logic [2:0] ostep;
    logic       nb_check;
    logic       div_start;
    logic       div_sel;
    logic       out_fin;
  } scdr_cmd_t;

  typedef struct packed {
    logic len_zero;
    logic div_busy;
    logic div_done;
    logic out_free;
  } scdr_stat_t;

  typedef struct packed {
    logic        sat;
    logic [63:0] val;
  } sat64_t;

  function automatic sat64_t sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    sat64_t      r;
    s     = {a[63], a} + {b[63], b};
    r.sat = s[64] ^ s[63];
    if (r.sat) begin
      r.val = s[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    end else begin
      r.val = s[63:0];
    end
    return r;
  endfunction

endpackage

FILE: hdl/scdr_div.sv
// ============================================================================
// scdr_div - radix-4 restoring fraction divider
// floor(num * 2^FRAC_BITS / den), clamped to 2^31 - 1; two quotient bits
// per cycle, or the clamp loaded directly when the quotient overflows.
// ============================================================================
module scdr_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] num,
  input  logic [63:0] den,
  output logic        busy,
  output logic        done,
  output logic [30:0] quot
);
  localparam int NW     = 64 + FRAC_BITS;
  localparam int QW     = 32;
  localparam int RBITS  = 2;
  localparam int NSTEP  = QW / RBITS;
  localparam int CNT_W  = $clog2(NSTEP);

  logic [NW-1:0]    nfull;
  logic             ovf;
  logic [63:0]      rem_r, rem_nxt, den_r;
  logic [QW-1:0]    nlo_r, nlo_nxt, q_r, q_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r, done_r;
  logic [64:0]      trial;

  assign nfull = {num, {FRAC_BITS{1'b0}}};
  // quotient >= 2^31 exactly when floor(N / 2^31) >= den
  assign ovf   = {{(95-NW){1'b0}}, nfull[NW-1:31]} >= den;

  always_comb begin
    rem_nxt = rem_r;
    nlo_nxt = nlo_r;
    q_nxt   = q_r;
    trial   = '0;
    for (int i = 0; i < RBITS; i++) begin
      trial   = {rem_nxt, nlo_nxt[QW-1]};
      nlo_nxt = {nlo_nxt[QW-2:0], 1'b0};
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = 64'(trial - {1'b0, den_r});
        q_nxt   = {q_nxt[QW-2:0], 1'b1};
      end else begin
        rem_nxt = trial[63:0];
        q_nxt   = {q_nxt[QW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        if (ovf) begin
          q_r    <= 32'h7FFF_FFFF;
          done_r <= 1'b1;
        end else begin
          busy_r <= 1'b1;
          cnt_r  <= '0;
          rem_r  <= {{(96-NW){1'b0}}, nfull[NW-1:32]};
          nlo_r  <= nfull[QW-1:0];
          q_r    <= '0;
          den_r  <= den;
        end
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        nlo_r <= nlo_nxt;
        q_r   <= q_nxt;
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(NSTEP - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quot = q_r[30:0];

endmodule

FILE: hdl/scdr_dp.sv
// ============================================================================
// scdr_dp - datapath of the SPH density rate core
// Own-particle registers, neighbour operands, one shared 33x33 multiplier
// with registered product, the sums, the divider and the result register.
// ============================================================================
module scdr_dp #(
  parameter int FRAC_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  scdr_pkg::scdr_cmd_t    cmd,
  output scdr_pkg::scdr_stat_t   stat,
  input  logic [2:0][31:0]       in_pos,
  input  logic [2:0][31:0]       in_vel,
  input  logic [2:0][31:0]       in_grad,
  input  logic [30:0]            in_density,
  input  logic                   delta_en,
  input  logic [30:0]            mass,
  input  logic [30:0]            dcoef,
  input  logic [30:0]            smooth,
  input  logic [30:0]            sound,
  input  logic                   out_ready,
  output logic                   out_valid,
  output logic [31:0]            out_rate,
  output logic                   out_zero_dist,
  output logic                   out_sat
);
  import scdr_pkg::*;

  logic [2:0][31:0] own_pos_r, own_vel_r;
  logic [30:0]      own_den_r, rn_r;
  logic [2:0][31:0] d_mag_r, g_mag_r;
  logic [2:0][32:0] dv_mag_r;
  logic [2:0]       d_neg_r, dv_neg_r, g_neg_r;
  logic [63:0]      len2_r, pos_r, neg_r, csum_r, cs_r, ds_r, dmag_r, tot_r, t_r;
  logic [63:0]      prod_r, ph_r;
  logic             rneg_r, dneg_r, zf_r, sat_r, prod_neg_r, div_sel_r;
  logic [2:0]       prod_sel_r, prod_ostep_r;
  logic [1:0]       prod_comp_r;
  logic [30:0]      rf_r, rr_r;
  logic             out_v_r, out_zd_r, out_sat_r;
  logic [31:0]      out_rate_r;

  logic [2:0][32:0] pdiff, vdiff, dv_mag_c;
  logic [2:0][31:0] d_val, d_mag_c, g_mag_c;
  logic [32:0]      mul_a, mul_b;
  logic [65:0]      mul_full;
  logic [63:0]      src, src_mag;
  logic [31:0]      bsel;
  logic [95:0]      full96, shift96;
  logic             over;
  logic [62:0]      m63;
  logic [63:0]      comb_res, con_m, con_v, rr_m, rr_v, total;
  logic [31:0]      rho_diff;
  logic [30:0]      rho_mag;
  logic [63:0]      div_num, div_den;
  logic             div_busy, div_done;
  logic [30:0]      div_q;
  sat64_t           cs_add, ds_add, fin_add;
  logic             fin_sat, in32;

  // neighbour operands, per component
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      pdiff[c] = {own_pos_r[c][31], own_pos_r[c]} - {in_pos[c][31], in_pos[c]};
      if (pdiff[c][32] != pdiff[c][31]) begin
        d_val[c] = pdiff[c][32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end else begin
        d_val[c] = pdiff[c][31:0];
      end
      d_mag_c[c]  = d_val[c][31] ? 32'(-d_val[c]) : d_val[c];
      vdiff[c]    = {in_vel[c][31], in_vel[c]} - {own_vel_r[c][31], own_vel_r[c]};
      dv_mag_c[c] = vdiff[c][32] ? 33'(-vdiff[c]) : vdiff[c];
      g_mag_c[c]  = in_grad[c][31] ? 32'(-in_grad[c]) : in_grad[c];
    end
  end

  // shared multiplier operands
  always_comb begin
    unique case (cmd.ostep)
      OSTEP_CONT:  src = cs_r;
      OSTEP_DCOEF: src = ds_r;
      default:     src = t_r;
    endcase
    src_mag = src[63] ? 64'(-src) : src;
    unique case (cmd.ostep)
      OSTEP_CONT, OSTEP_MASS: bsel = {1'b0, mass};
      OSTEP_DCOEF:            bsel = {dcoef, 1'b0};
      OSTEP_SMOOTH:           bsel = {1'b0, smooth};
      default:                bsel = {1'b0, sound};
    endcase
    unique case (cmd.mul_sel)
      MUL_LEN: begin
        mul_a = {1'b0, d_mag_r[cmd.comp]};
        mul_b = {1'b0, d_mag_r[cmd.comp]};
      end
      MUL_CON: begin
        mul_a = dv_mag_r[cmd.comp];
        mul_b = {1'b0, g_mag_r[cmd.comp]};
      end
      MUL_DOT: begin
        mul_a = {1'b0, d_mag_r[cmd.comp]};
        mul_b = {1'b0, g_mag_r[cmd.comp]};
      end
      MUL_RR: begin
        mul_a = {2'b0, rf_r};
        mul_b = {2'b0, rr_r};
      end
      MUL_HI: begin
        mul_a = {1'b0, src_mag[63:32]};
        mul_b = {1'b0, bsel};
      end
      MUL_LO: begin
        mul_a = {1'b0, src_mag[31:0]};
        mul_b = {1'b0, bsel};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_full = mul_a * mul_b;
  end

  // write-back values
  always_comb begin
    full96   = {ph_r, 32'b0} + {32'b0, prod_r};
    shift96  = full96 >> FRAC_BITS;
    over     = |shift96[95:63];
    m63      = over ? {63{1'b1}} : shift96[62:0];
    comb_res = prod_neg_r ? 64'(-{1'b0, m63}) : {1'b0, m63};

    con_m = prod_r >> FRAC_BITS;
    con_v = (dv_neg_r[prod_comp_r] ^ g_neg_r[prod_comp_r]) ? 64'(-con_m) : con_m;
    rr_m  = prod_r >> FRAC_BITS;
    rr_v  = (rneg_r != dneg_r) ? 64'(-rr_m) : rr_m;

    cs_add = sat_add(cs_r, csum_r);
    ds_add = sat_add(ds_r, rr_v);

    rho_diff = {1'b0, rn_r} - {1'b0, own_den_r};
    rho_mag  = rho_diff[31] ? 31'(-rho_diff) : rho_diff[30:0];
    div_num  = (cmd.div_sel == DIV_RR) ? {33'b0, rho_mag} : dmag_r;
    div_den  = (cmd.div_sel == DIV_RR) ? {33'b0, rn_r} : len2_r;

    fin_add = sat_add(tot_r, t_r);
    total   = delta_en ? fin_add.val : tot_r;
    in32    = (total[63:31] == '0) || (total[63:31] == '1);
    fin_sat = sat_r | (delta_en & fin_add.sat) | ~in32;
  end

  scdr_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .quot  (div_q)
  );

  // control-side registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_pos_r  <= '0;
      own_vel_r  <= '0;
      own_den_r  <= 31'(1) << FRAC_BITS;
      cs_r       <= '0;
      ds_r       <= '0;
      zf_r       <= 1'b0;
      sat_r      <= 1'b0;
      prod_sel_r <= MUL_NONE;
      out_v_r    <= 1'b0;
    end else begin
      prod_sel_r <= cmd.mul_sel;
      if (cmd.load_own) begin
        own_pos_r <= in_pos;
        own_vel_r <= in_vel;
        own_den_r <= in_density;
        cs_r      <= '0;
        ds_r      <= '0;
        zf_r      <= 1'b0;
      end else if (cmd.nb_check) begin
        if (len2_r == '0) begin
          zf_r <= 1'b1;
        end else begin
          cs_r <= cs_add.val;
        end
      end else if (prod_sel_r == MUL_RR) begin
        ds_r <= ds_add.val;
      end else if (prod_sel_r == MUL_LO) begin
        sat_r <= sat_r | over;
      end else if (cmd.out_fin) begin
        cs_r  <= '0;
        ds_r  <= '0;
        zf_r  <= 1'b0;
        sat_r <= 1'b0;
      end
      if (cmd.out_fin) begin
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // operand and accumulator registers
  always_ff @(posedge clk) begin
    prod_r       <= mul_full[63:0];
    prod_comp_r  <= cmd.comp;
    prod_ostep_r <= cmd.ostep;
    prod_neg_r   <= src[63];
    if (cmd.load_nb) begin
      for (int c = 0; c < 3; c++) begin
        d_mag_r[c]  <= d_mag_c[c];
        d_neg_r[c]  <= d_val[c][31];
        dv_mag_r[c] <= dv_mag_c[c];
        dv_neg_r[c] <= vdiff[c][32];
        g_mag_r[c]  <= g_mag_c[c];
        g_neg_r[c]  <= in_grad[c][31];
      end
      rn_r   <= (in_density == '0) ? 31'd1 : in_density;
      len2_r <= '0;
      csum_r <= '0;
      pos_r  <= '0;
      neg_r  <= '0;
    end
    unique case (prod_sel_r)
      MUL_LEN: len2_r <= len2_r + prod_r;
      MUL_CON: csum_r <= csum_r + con_v;
      MUL_DOT: begin
        if (d_neg_r[prod_comp_r] != g_neg_r[prod_comp_r]) begin
          neg_r <= neg_r + prod_r;
        end else begin
          pos_r <= pos_r + prod_r;
        end
      end
      MUL_HI: ph_r <= prod_r;
      MUL_LO: begin
        if (prod_ostep_r == OSTEP_CONT) begin
          tot_r <= comb_res;
        end else begin
          t_r <= comb_res;
        end
      end
      default: ;
    endcase
    if (cmd.nb_check) begin
      rneg_r <= pos_r > neg_r;
      dmag_r <= (pos_r > neg_r) ? pos_r - neg_r : neg_r - pos_r;
    end
    if (cmd.div_start) begin
      div_sel_r <= cmd.div_sel;
      if (cmd.div_sel == DIV_RR) begin
        dneg_r <= rho_diff[31];
      end
    end
    if (div_done) begin
      if (div_sel_r == DIV_RR) begin
        rr_r <= div_q;
      end else begin
        rf_r <= div_q;
      end
    end
    if (cmd.out_fin) begin
      out_rate_r <= in32 ? total[31:0]
                         : (total[63] ? 32'h8000_0000 : 32'h7FFF_FFFF);
      out_zd_r   <= zf_r;
      out_sat_r  <= fin_sat;
    end
  end

  assign stat.len_zero  = (len2_r == '0);
  assign stat.div_busy  = div_busy;
  assign stat.div_done  = div_done;
  assign stat.out_free  = ~out_v_r | out_ready;

  assign out_valid     = out_v_r;
  assign out_rate      = out_rate_r;
  assign out_zero_dist = out_zd_r;
  assign out_sat       = out_sat_r;

endmodule

FILE: hdl/scdr_ctrl.sv
// ============================================================================
// scdr_ctrl - sequencer of the SPH density rate core
// Walks one item through the multiplier passes, the two divisions and the
// output multiply chain, issuing datapath commands.
// ============================================================================
module scdr_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_mode,
  input  logic                  in_last,
  output logic                  in_ready,
  input  logic                  dims3,
  input  logic                  delta_en,
  input  scdr_pkg::scdr_stat_t  stat,
  output scdr_pkg::scdr_cmd_t   cmd
);
  import scdr_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_NB_MUL   = 4'd1;
  localparam logic [3:0] S_NB_FLUSH = 4'd2;
  localparam logic [3:0] S_NB_CHECK = 4'd3;
  localparam logic [3:0] S_DIV1     = 4'd4;
  localparam logic [3:0] S_DIV1_W   = 4'd5;
  localparam logic [3:0] S_DIV2     = 4'd6;
  localparam logic [3:0] S_DIV2_W   = 4'd7;
  localparam logic [3:0] S_RR_MUL   = 4'd8;
  localparam logic [3:0] S_RR_WB    = 4'd9;
  localparam logic [3:0] S_OUT_HI   = 4'd10;
  localparam logic [3:0] S_OUT_LO   = 4'd11;
  localparam logic [3:0] S_OUT_WB   = 4'd12;
  localparam logic [3:0] S_OUT_FIN  = 4'd13;

  logic [3:0] state_r, state_nxt;
  logic [1:0] comp_r, comp_nxt;
  logic [2:0] kind_r, kind_nxt, ostep_r, ostep_nxt;
  logic       last_r, last_nxt;
  logic       accept;
  logic [1:0] last_comp;
  logic [2:0] last_ostep;
  logic [3:0] done_state;

  assign in_ready   = (state_r == S_IDLE);
  assign accept     = in_valid & in_ready;
  assign last_comp  = dims3 ? 2'd2 : 2'd1;
  assign last_ostep = delta_en ? OSTEP_MASS : OSTEP_CONT;
  assign done_state = last_r ? S_OUT_HI : S_IDLE;

  always_comb begin
    state_nxt = state_r;
    comp_nxt  = comp_r;
    kind_nxt  = kind_r;
    ostep_nxt = ostep_r;
    last_nxt  = last_r;
    cmd       = '0;
    cmd.comp  = comp_r;
    cmd.ostep = ostep_r;
    unique case (state_r)
      S_IDLE: begin
        comp_nxt  = '0;
        kind_nxt  = MUL_LEN;
        ostep_nxt = OSTEP_CONT;
        if (accept) begin
          last_nxt = in_last;
          if (in_mode == MODE_BEGIN) begin
            cmd.load_own = 1'b1;
            state_nxt    = in_last ? S_OUT_HI : S_IDLE;
          end else begin
            cmd.load_nb = 1'b1;
            state_nxt   = S_NB_MUL;
          end
        end
      end
      S_NB_MUL: begin
        cmd.mul_sel = kind_r;
        if (kind_r == MUL_DOT) begin
          kind_nxt = MUL_LEN;
          comp_nxt = comp_r + 1'b1;
          if (comp_r == last_comp) begin
            state_nxt = S_NB_FLUSH;
          end
        end else begin
          kind_nxt = kind_r + 1'b1;
        end
      end
      S_NB_FLUSH: state_nxt = S_NB_CHECK;
      S_NB_CHECK: begin
        cmd.nb_check = 1'b1;
        if (stat.len_zero || !delta_en) begin
          state_nxt = done_state;
        end else begin
          state_nxt = S_DIV1;
        end
      end
      S_DIV1: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_RF;
        state_nxt     = S_DIV1_W;
      end
      S_DIV1_W: if (stat.div_done) state_nxt = S_DIV2;
      S_DIV2: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_RR;
        state_nxt     = S_DIV2_W;
      end
      S_DIV2_W: if (stat.div_done) state_nxt = S_RR_MUL;
      S_RR_MUL: begin
        cmd.mul_sel = MUL_RR;
        state_nxt   = S_RR_WB;
      end
      S_RR_WB: state_nxt = done_state;
      S_OUT_HI: begin
        cmd.mul_sel = MUL_HI;
        state_nxt   = S_OUT_LO;
      end
      S_OUT_LO: begin
        cmd.mul_sel = MUL_LO;
        state_nxt   = S_OUT_WB;
      end
      S_OUT_WB: begin
        if (ostep_r == last_ostep) begin
          state_nxt = S_OUT_FIN;
        end else begin
          ostep_nxt = ostep_r + 1'b1;
          state_nxt = S_OUT_HI;
        end
      end
      S_OUT_FIN: begin
        if (stat.out_free) begin
          cmd.out_fin = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      comp_r  <= '0;
      kind_r  <= MUL_LEN;
      ostep_r <= OSTEP_CONT;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      comp_r  <= comp_nxt;
      kind_r  <= kind_nxt;
      ostep_r <= ostep_nxt;
      last_r  <= last_nxt;
    end
  end

`ifndef SYNTH
  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> !stat.div_busy)
    else $error("divider started while busy");

  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_fin |-> stat.out_free)
    else $error("result written over an untaken beat");

  a_nb_start: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_mode != MODE_BEGIN) |=> (state_r == S_NB_MUL))
    else $error("neighbour beat did not start the multiply passes");
`endif

endmodule

FILE: hdl/sph_continuity_density_rate_core.sv
// ============================================================================
// sph_continuity_density_rate_core - SPH continuity density rate, delta-SPH
// Top level: stream ports, configuration registers, sequencer and datapath.
// ============================================================================
// One particle is a run of beats: a begin beat (tuser 0) loads own position,
// velocity and density; each neighbour beat (tuser 1) adds mass-free
// dot(dv, grad) to the continuity sum and, with delta enabled, the delta-SPH
// diffusion term. The beat with tlast emits one result: density rate
// (saturated Q format) with tuser {saturated, zero_distance_seen}. Neighbours
// at zero distance are skipped and flagged. One item at a time: a neighbour
// beat makes one pass of the shared multiplier per product, three products
// per component over D = 2 or 3 dimensions, and with delta enabled two
// radix-4 divisions in the shared divider. A last beat then runs the output
// multiply chain. The result sits in an output register, so the next beat is
// taken while it waits. Config writes are taken every cycle and must only
// happen while idle.
// ============================================================================
module sph_continuity_density_rate_core #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, grad_x, grad_y, grad_z,
  // density[30:0], one pad bit
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [scdr_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  logic [0:0]                          in_tuser,   // mode
  input  logic                                in_tlast,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [scdr_pkg::OUT_TDATA_W-1:0]    out_tdata,  // density_rate
  output logic [scdr_pkg::OUT_TUSER_W-1:0]    out_tuser,  // zero_distance_seen, saturated
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [scdr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [scdr_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import scdr_pkg::*;

  logic [1:0]       dimension_r;
  logic [30:0]      mass_r, dcoef_r, smooth_r, sound_r;
  logic             delta_en_r;
  logic [2:0][31:0] in_pos, in_vel, in_grad;
  scdr_cmd_t        cmd;
  scdr_stat_t       stat;
  logic             out_zd, out_sat;

  // configuration registers; always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dimension_r <= 2'd2;
      mass_r      <= 31'd65536;
      delta_en_r  <= 1'b0;
      dcoef_r     <= 31'd6554;
      smooth_r    <= 31'd65536;
      sound_r     <= 31'd65536;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_DIMENSION:  dimension_r <= cfg_data[1:0];
        CFG_MASS:       mass_r      <= cfg_data;
        CFG_DELTA_EN:   delta_en_r  <= cfg_data[0];
        CFG_DELTA_COEF: dcoef_r     <= cfg_data;
        CFG_SMOOTH:     smooth_r    <= cfg_data;
        CFG_SOUND:      sound_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  // unpack the input beat
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      in_pos[c]  = in_tdata[32*c +: 32];
      in_vel[c]  = in_tdata[96 + 32*c +: 32];
      in_grad[c] = in_tdata[192 + 32*c +: 32];
    end
  end

  scdr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_mode  (in_tuser[0]),
    .in_last  (in_tlast),
    .in_ready (in_tready),
    .dims3    (dimension_r == DIM_3D),
    .delta_en (delta_en_r),
    .stat     (stat),
    .cmd      (cmd)
  );

  scdr_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .in_pos        (in_pos),
    .in_vel        (in_vel),
    .in_grad       (in_grad),
    .in_density    (in_tdata[318:288]),
    .delta_en      (delta_en_r),
    .mass          (mass_r),
    .dcoef         (dcoef_r),
    .smooth        (smooth_r),
    .sound         (sound_r),
    .out_ready     (out_tready),
    .out_valid     (out_tvalid),
    .out_rate      (out_tdata),
    .out_zero_dist (out_zd),
    .out_sat       (out_sat)
  );

  assign out_tuser = {out_sat, out_zd};

endmodule

FILE: bench/sph_continuity_density_rate_core_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// sph_continuity_density_rate_core_tb - self-checking bench for the core
// Drives particle runs (begin beat, neighbour beats, tlast) with random
// idling and back-pressure, predicts each density rate in fixed point and
// compares every result beat, field by field, against the oldest prediction.
// ============================================================================
module sph_continuity_density_rate_core_tb;
  import scdr_pkg::*;

  localparam int  FRAC      = 16;
  localparam int  CYC_LIMIT = 1000000;
  localparam int  DRAIN     = 100;            // allowance for the worst beat and the output chain
  localparam int  PHASE_CNT = 6;
  localparam int  PHASE_BEATS = 150;
  localparam longint I64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint I64_MIN = 64'sh8000_0000_0000_0000;
  localparam longint M31 = 64'h7FFF_FFFF;

  typedef struct {
    logic             mode;
    logic [2:0][31:0] pos;
    logic [2:0][31:0] vel;
    logic [2:0][31:0] grad;
    logic [30:0]      dens;
    logic             last;
    logic             known;   // expected result typed into the table
    logic [31:0]      k_rate;
    logic             k_zd;
    logic             k_sat;
  } beat_t;

  typedef struct {
    logic [31:0] rate;
    logic        zd;
    logic        sat;
  } rate_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_tvalid, in_tready, in_tlast;
  logic [IN_TDATA_W-1:0] in_tdata;
  logic [0:0] in_tuser;
  logic out_tvalid, out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [OUT_TUSER_W-1:0] out_tuser;
  logic cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  sph_continuity_density_rate_core dut (.*);

  always #5 clk = ~clk;

  // settings mirrored for prediction
  logic [1:0]  dim_r;
  logic [30:0] mass_r, coef_r, smooth_r, sound_r;
  logic        den_r;

  // particle state of the predictor
  longint own_pos[3], own_vel[3], own_rho, cont_acc, diff_acc;
  bit     zd_seen;

  rate_t  rate_q[$];
  int     err_cnt = 0;
  int     cyc = 0;
  bit     quiet = 0;        // no idling on either side
  int     hold_req = 0;     // bumped to ask the receiver for a long hold-off
  int     hold_seen = 0;
  int     hold_left = 0;

  // ---------------------------------------------------------------- arithmetic
  function automatic longint unsigned mag64(longint x);
    return x < 0 ? 64'(-x) : 64'(x);
  endfunction

  function automatic longint clamp32(longint x);
    if (x > 64'sh7FFF_FFFF) return 64'sh7FFF_FFFF;
    if (x < -64'sh8000_0000) return -64'sh8000_0000;
    return x;
  endfunction

  function automatic longint add_sat64(longint a, longint b, inout bit sat);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s > 65'(I64_MAX)) begin
      sat = 1;
      return I64_MAX;
    end
    if (s < 65'(I64_MIN)) begin
      sat = 1;
      return I64_MIN;
    end
    return longint'(s[63:0]);
  endfunction

  // signed a times unsigned Q b, magnitude truncated, capped at 2^63 - 1
  function automatic longint scale_q(longint a, longint unsigned b, inout bit sat);
    logic [127:0] p;
    longint       m;
    p = ({64'b0, mag64(a)} * {64'b0, b}) >> FRAC;
    if (p > 128'(I64_MAX)) begin
      sat = 1;
      m = I64_MAX;
    end else begin
      m = longint'(p[63:0]);
    end
    return a < 0 ? -m : m;
  endfunction

  // advance the particle state by one accepted beat; returns 1 with a result
  function automatic bit rate_predict(beat_t b, output rate_t r);
    int dims;
    longint d[3], g[3], dv, csum, num, tot, t;
    longint unsigned len2, pos_s, neg_s, m, rf, rr, rn, mg;
    logic [127:0] q;
    bit sat, dummy, rneg, dneg;
    dims = (dim_r == DIM_3D) ? 3 : 2;
    sat = 0;
    dummy = 0;
    r = '{default: '0};
    if (b.mode == MODE_BEGIN) begin
      for (int c = 0; c < 3; c++) begin
        own_pos[c] = $signed(b.pos[c]);
        own_vel[c] = $signed(b.vel[c]);
      end
      own_rho = longint'(b.dens);
      cont_acc = 0;
      diff_acc = 0;
      zd_seen = 0;
    end else begin
      len2 = 0;
      for (int c = 0; c < dims; c++) begin
        d[c] = clamp32(own_pos[c] - longint'($signed(b.pos[c])));
        g[c] = $signed(b.grad[c]);
        len2 += mag64(d[c]) * mag64(d[c]);
      end
      if (len2 == 0) begin
        zd_seen = 1;    // coincident neighbour: skipped
      end else begin
        csum = 0;
        for (int c = 0; c < dims; c++) begin
          dv = longint'($signed(b.vel[c])) - own_vel[c];
          m = (mag64(dv) * mag64(g[c])) >> FRAC;
          csum += ((dv < 0) != (g[c] < 0)) ? -longint'(m) : longint'(m);
        end
        cont_acc = add_sat64(cont_acc, csum, dummy);
        if (den_r) begin
          pos_s = 0;
          neg_s = 0;
          for (int c = 0; c < dims; c++) begin
            m = mag64(d[c]) * mag64(g[c]);
            if ((d[c] < 0) != (g[c] < 0)) neg_s += m;
            else pos_s += m;
          end
          rneg = pos_s > neg_s;
          mg = rneg ? pos_s - neg_s : neg_s - pos_s;
          q = ({64'b0, mg} << FRAC) / {64'b0, len2};
          rf = (q > 128'(M31)) ? M31 : q[63:0];
          rn = (b.dens == 0) ? 1 : longint'(b.dens);   // zero density taken as one LSB
          num = longint'(rn) - own_rho;
          dneg = num < 0;
          rr = (mag64(num) << FRAC) / rn;
          if (rr > M31) rr = M31;
          mg = (rf * rr) >> FRAC;
          diff_acc = add_sat64(diff_acc, (rneg != dneg) ? -longint'(mg) : longint'(mg),
                               dummy);
        end
      end
    end
    if (!b.last) return 0;
    tot = scale_q(cont_acc, mass_r, sat);
    if (den_r) begin
      t = scale_q(diff_acc, 64'(coef_r) << 1, sat);
      t = scale_q(t, smooth_r, sat);
      t = scale_q(t, sound_r, sat);
      t = scale_q(t, mass_r, sat);
      tot = add_sat64(tot, t, sat);
    end
    if (tot != clamp32(tot)) sat = 1;
    r.rate = 32'(clamp32(tot));
    r.zd = zd_seen;
    r.sat = sat;
    cont_acc = 0;
    diff_acc = 0;
    zd_seen = 0;
    return 1;
  endfunction

  // ---------------------------------------------------------------- drivers
  function automatic logic [31:0] rnd_q();
    int sel;
    logic [31:0] v;
    sel = $urandom_range(0, 9);
    case (sel)
      0: v = $urandom;
      1: v = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: begin
        v = $urandom_range(0, 32'h0004_0000);
        if ($urandom_range(0, 1)) v = -v;
      end
    endcase
    return v;
  endfunction

  function automatic logic [30:0] rnd_rho();
    case ($urandom_range(0, 9))
      0: return 31'($urandom);
      1: return $urandom_range(0, 1) ? 31'h7FFF_FFFF : 31'd0;
      default: return 31'($urandom_range(32'h0000_8000, 32'h0002_0000));
    endcase
  endfunction

  function automatic beat_t rnd_beat(logic mode, logic last);
    beat_t b;
    b = '{default: '0};
    b.mode = mode;
    b.last = last;
    for (int c = 0; c < 3; c++) begin
      b.pos[c] = rnd_q();
      b.vel[c] = rnd_q();
      b.grad[c] = rnd_q();
    end
    b.dens = rnd_rho();
    // coincident neighbour now and then
    if (mode != MODE_BEGIN && $urandom_range(0, 99) < 8)
      for (int c = 0; c < 3; c++) b.pos[c] = 32'(own_pos[c]);
    return b;
  endfunction

  task automatic send_beat(beat_t b);
    rate_t r;
    while (!quiet && $urandom_range(0, 99) < 15) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= b.mode;
    in_tlast <= b.last;
    in_tdata <= {1'b0, b.dens, b.grad[2], b.grad[1], b.grad[0],
                 b.vel[2], b.vel[1], b.vel[0], b.pos[2], b.pos[1], b.pos[0]};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (rate_predict(b, r)) begin
      if (b.known) rate_q.push_back('{b.k_rate, b.k_zd, b.k_sat});
      else rate_q.push_back(r);
    end
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (rate_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [30:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_DIMENSION:  dim_r = val[1:0];
      CFG_MASS:       mass_r = val;
      CFG_DELTA_EN:   den_r = val[0];
      CFG_DELTA_COEF: coef_r = val;
      CFG_SMOOTH:     smooth_r = val;
      CFG_SOUND:      sound_r = val;
      default: ;
    endcase
  endtask

  function automatic beat_t row(logic mode, logic last, logic [31:0] p, logic [31:0] v,
                                logic [31:0] g, logic [30:0] rho);
    beat_t b;
    b = '{default: '0};
    b.mode = mode;
    b.last = last;
    for (int c = 0; c < 3; c++) begin
      b.pos[c] = p;
      b.vel[c] = v;
      b.grad[c] = g;
    end
    b.dens = rho;
    return b;
  endfunction

  // ---------------------------------------------------------------- receiver
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= 400;     // long hold-off: the core fills and stalls in_tready
      out_tready <= 1'b0;
    end else begin
      out_tready <= quiet || ($urandom_range(0, 99) >= 15);
    end
  end

  // result check against the oldest prediction
  always @(posedge clk) begin
    rate_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (rate_q.size() == 0) begin
        $error("unexpected result beat: density_rate %h", out_tdata);
        err_cnt++;
      end else begin
        e = rate_q.pop_front();
        if (out_tdata !== e.rate) begin
          $error("density_rate: expected %h, got %h", e.rate, out_tdata);
          err_cnt++;
        end
        if (out_tuser[0] !== e.zd) begin
          $error("zero_distance_seen: expected %b, got %b", e.zd, out_tuser[0]);
          err_cnt++;
        end
        if (out_tuser[1] !== e.sat) begin
          $error("saturated: expected %b, got %b", e.sat, out_tuser[1]);
          err_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc == CYC_LIMIT) begin
      $display("sph_continuity_density_rate_core_tb: errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus
  initial begin
    beat_t dir_tab[$];
    beat_t b;
    int sent, nb;
    logic [30:0] ph_cfg[PHASE_CNT][6];
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tuser <= '0;
    in_tlast <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    // reset values of the registers and particle state
    dim_r = 2;
    mass_r = 65536;
    den_r = 0;
    coef_r = 6554;
    smooth_r = 65536;
    sound_r = 65536;
    foreach (own_pos[c]) begin
      own_pos[c] = 0;
      own_vel[c] = 0;
    end
    own_rho = 64'(1) << FRAC;
    cont_acc = 0;
    diff_acc = 0;
    zd_seen = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table; typed results only where obvious
    // neighbour straight after reset at the reset own position: coincident
    b = row(1, 1, 32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF);
    b.known = 1; b.k_rate = 0; b.k_zd = 1; b.k_sat = 0;
    dir_tab.push_back(b);
    // begin with last: zero rate, flags clear
    b = row(0, 1, 32'h8000_0000, 32'h8000_0000, 32'h0, 31'h7FFF_FFFF);
    b.known = 1; b.k_rate = 0; b.k_zd = 0; b.k_sat = 0;
    dir_tab.push_back(b);
    // extremes of position and velocity, saturating dot products
    dir_tab.push_back(row(0, 0, 32'h8000_0000, 32'h8000_0000, 32'h0, 31'h1));
    dir_tab.push_back(row(1, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h0));
    dir_tab.push_back(row(1, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF));
    dir_tab.push_back(row(1, 1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'h1));
    // ordinary particle, zero-distance neighbour mixed in
    dir_tab.push_back(row(0, 0, 32'h0001_0000, 32'h0000_8000, 32'h0, 31'h0001_0000));
    dir_tab.push_back(row(1, 0, 32'h0002_0000, 32'hFFFF_0000, 32'h0000_4000, 31'h0001_2000));
    dir_tab.push_back(row(1, 0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 31'h0000_F000));
    dir_tab.push_back(row(1, 1, 32'hFFFF_0000, 32'h0003_0000, 32'hFFFF_C000, 31'h0));
    // neighbours carrying on from the last loaded own data, no begin
    dir_tab.push_back(row(1, 0, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0001, 31'h0000_0001));
    dir_tab.push_back(row(1, 1, 32'h1234_5678, 32'hEDCB_A988, 32'h0000_FFFF, 31'h0001_0000));
    foreach (dir_tab[i]) send_beat(dir_tab[i]);
    drain_results();

    // register settings per phase: dimension, mass, delta, coefficient, h, c
    ph_cfg[0] = '{3, 65536, 1, 6554, 65536, 65536};
    ph_cfg[1] = '{2, 31'h7FFF_FFFF, 1, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF};
    ph_cfg[2] = '{0, 0, 0, 0, 0, 0};
    ph_cfg[3] = '{1, 31'($urandom), 1, 31'($urandom_range(0, 32'h0002_0000)),
                  31'($urandom_range(0, 32'h0004_0000)), 31'($urandom)};
    ph_cfg[4] = '{3, 32768, 1, 13107, 131072, 31'h000A_0000};
    ph_cfg[5] = '{3, 31'h7FFF_FFFF, 0, 0, 31'h7FFF_FFFF, 0};

    for (int ph = 0; ph < PHASE_CNT; ph++) begin
      cfg_write(CFG_DIMENSION, ph_cfg[ph][0]);
      cfg_write(CFG_MASS, ph_cfg[ph][1]);
      cfg_write(CFG_DELTA_EN, ph_cfg[ph][2]);
      cfg_write(CFG_DELTA_COEF, ph_cfg[ph][3]);
      cfg_write(CFG_SMOOTH, ph_cfg[ph][4]);
      cfg_write(CFG_SOUND, ph_cfg[ph][5]);
      quiet = (ph == 0);          // first random phase runs without idling
      if (ph == 1) hold_req++;    // receiver stalls while we keep offering beats
      sent = 0;
      while (sent < PHASE_BEATS) begin
        if ($urandom_range(0, 9) == 0) begin
          // noise: stray neighbour or begin, random tlast
          send_beat(rnd_beat($urandom_range(0, 1), $urandom_range(0, 1)));
          sent++;
        end else begin
          nb = $urandom_range(0, 6);
          send_beat(rnd_beat(MODE_BEGIN, nb == 0));
          for (int k = 1; k <= nb; k++) send_beat(rnd_beat(1, k == nb));
          sent += nb + 1;
        end
        // in phase 3, sender pause mid phase until every result is back
        if (ph == 3 && sent >= PHASE_BEATS / 2 && sent < PHASE_BEATS / 2 + 8) begin
          in_tvalid <= 1'b0;
          while (rate_q.size() != 0) @(posedge clk);
        end
      end
      quiet = 0;
      drain_results();
    end

    if (err_cnt == 0) begin
      $display("sph_continuity_density_rate_core_tb: clean");
    end else begin
      $display("sph_continuity_density_rate_core_tb: errors");
    end
    $finish;
  end

endmodule
